FILE: sv/cfc_pkg.sv
// ----------------------------------------------------------------------------
// cfc_pkg
// Shared widths, codes, stage payload types and the face adjacency lookup
// for the cube face coordinate stepper.
// ----------------------------------------------------------------------------
package cfc_pkg;

  localparam int FACE_W    = 3;
  localparam int ROT_W     = 2;
  localparam int TILE_W    = 6;   // log2 of tiles per face edge
  localparam int PIX_W     = 6;   // log2 of pixels per tile edge
  localparam int FRAC_BITS = 8;
  localparam int FRAC_W    = FRAC_BITS + 1;
  localparam int STEP_W    = 7;
  localparam int SUM_W     = TILE_W + 2;

  localparam logic [FRAC_W-1:0]        FRAC_ONE = FRAC_W'(1 << FRAC_BITS);
  localparam logic signed [STEP_W-1:0] STEP_LIM = STEP_W'((1 << TILE_W) - 1);
  localparam logic signed [STEP_W-1:0] STEP_POS = STEP_W'(1);
  localparam logic signed [STEP_W-1:0] STEP_NEG = -STEP_W'(1);

  localparam logic [FACE_W-1:0] FACE_FRONT  = 3'd0;
  localparam logic [FACE_W-1:0] FACE_BACK   = 3'd1;
  localparam logic [FACE_W-1:0] FACE_LEFT   = 3'd2;
  localparam logic [FACE_W-1:0] FACE_RIGHT  = 3'd3;
  localparam logic [FACE_W-1:0] FACE_TOP    = 3'd4;
  localparam logic [FACE_W-1:0] FACE_BOTTOM = 3'd5;
  localparam logic [FACE_W-1:0] FACE_NONE   = 3'd6;

  localparam logic [ROT_W-1:0] ROT_0   = 2'd0;
  localparam logic [ROT_W-1:0] ROT_90  = 2'd1;
  localparam logic [ROT_W-1:0] ROT_180 = 2'd2;
  localparam logic [ROT_W-1:0] ROT_270 = 2'd3;

  typedef enum logic [1:0] {
    DIR_EAST,
    DIR_WEST,
    DIR_NORTH,
    DIR_SOUTH
  } dir_e;

  typedef struct packed {
    logic [FACE_W-1:0] face;
    logic [ROT_W-1:0]  rot;
  } orient_t;

  typedef struct packed {
    logic                      operation;
    logic [FACE_W-1:0]         face;
    logic [ROT_W-1:0]          rot;
    logic [TILE_W-1:0]         tc;
    logic [TILE_W-1:0]         tr;
    logic [PIX_W-1:0]          pc;
    logic [PIX_W-1:0]          pr;
    logic [FRAC_W-1:0]         fc;
    logic [FRAC_W-1:0]         fr;
    logic signed [STEP_W-1:0]  sc;
    logic signed [STEP_W-1:0]  sr;
  } req_t;

  // after pixel wrap: tile step to apply and whether orientation is kept
  typedef struct packed {
    logic [FACE_W-1:0]         face;
    logic [ROT_W-1:0]          rot;
    logic [TILE_W-1:0]         tc;
    logic [TILE_W-1:0]         tr;
    logic [PIX_W-1:0]          pc;
    logic [PIX_W-1:0]          pr;
    logic [FRAC_W-1:0]         fc;
    logic [FRAC_W-1:0]         fr;
    logic signed [STEP_W-1:0]  sx;
    logic signed [STEP_W-1:0]  sy;
    logic                      keep_rot;
  } mid_t;

  // after tile wrap and edge lookup
  typedef struct packed {
    logic [FACE_W-1:0] face;
    logic [ROT_W-1:0]  rot;
    logic [TILE_W-1:0] tc;
    logic [TILE_W-1:0] tr;
    logic [PIX_W-1:0]  pc;
    logic [PIX_W-1:0]  pr;
    logic [FRAC_W-1:0] fc;
    logic [FRAC_W-1:0] fr;
    logic              hx;
    logic              vy;
    logic              keep_rot;
  } edge_t;

  typedef struct packed {
    logic [FACE_W-1:0] face;
    logic [ROT_W-1:0]  rot;
    logic [TILE_W-1:0] tc;
    logic [TILE_W-1:0] tr;
    logic [PIX_W-1:0]  pc;
    logic [PIX_W-1:0]  pr;
    logic [FRAC_W-1:0] fc;
    logic [FRAC_W-1:0] fr;
  } res_t;

  // neighbour face and rotation across one edge of a real face
  function automatic orient_t cfc_neighbor(logic [FACE_W-1:0] face, dir_e dir);
    orient_t o;
    o = '{face: FACE_NONE, rot: ROT_0};
    unique case (dir)
      DIR_EAST: begin
        case (face)
          FACE_FRONT:  o = '{FACE_RIGHT, ROT_0};
          FACE_BACK:   o = '{FACE_LEFT,  ROT_0};
          FACE_LEFT:   o = '{FACE_FRONT, ROT_0};
          FACE_RIGHT:  o = '{FACE_BACK,  ROT_0};
          FACE_TOP:    o = '{FACE_RIGHT, ROT_90};
          FACE_BOTTOM: o = '{FACE_RIGHT, ROT_270};
          default:     o = '{FACE_NONE,  ROT_0};
        endcase
      end
      DIR_WEST: begin
        case (face)
          FACE_FRONT:  o = '{FACE_LEFT,  ROT_0};
          FACE_BACK:   o = '{FACE_RIGHT, ROT_0};
          FACE_LEFT:   o = '{FACE_BACK,  ROT_0};
          FACE_RIGHT:  o = '{FACE_FRONT, ROT_0};
          FACE_TOP:    o = '{FACE_LEFT,  ROT_270};
          FACE_BOTTOM: o = '{FACE_LEFT,  ROT_90};
          default:     o = '{FACE_NONE,  ROT_0};
        endcase
      end
      DIR_NORTH: begin
        case (face)
          FACE_FRONT:  o = '{FACE_TOP,   ROT_0};
          FACE_BACK:   o = '{FACE_TOP,   ROT_180};
          FACE_LEFT:   o = '{FACE_TOP,   ROT_90};
          FACE_RIGHT:  o = '{FACE_TOP,   ROT_270};
          FACE_TOP:    o = '{FACE_BACK,  ROT_180};
          FACE_BOTTOM: o = '{FACE_FRONT, ROT_0};
          default:     o = '{FACE_NONE,  ROT_0};
        endcase
      end
      DIR_SOUTH: begin
        case (face)
          FACE_FRONT:  o = '{FACE_BOTTOM, ROT_0};
          FACE_BACK:   o = '{FACE_BOTTOM, ROT_180};
          FACE_LEFT:   o = '{FACE_BOTTOM, ROT_90};
          FACE_RIGHT:  o = '{FACE_BOTTOM, ROT_270};
          FACE_TOP:    o = '{FACE_FRONT,  ROT_0};
          FACE_BOTTOM: o = '{FACE_BACK,   ROT_180};
          default:     o = '{FACE_NONE,   ROT_0};
        endcase
      end
      default: o = '{FACE_NONE, ROT_0};
    endcase
    return o;
  endfunction

endpackage

FILE: sv/cfc_req_if.sv
// ----------------------------------------------------------------------------
// cfc_req_if
// Request channel: one cube coordinate and a signed step.
// ----------------------------------------------------------------------------
interface cfc_req_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [2:0]  face_in;
  logic [1:0]  rotation_in;
  logic [5:0]  tile_col_in;
  logic [5:0]  tile_row_in;
  logic [5:0]  pix_col_in;
  logic [5:0]  pix_row_in;
  logic [8:0]  frac_col_in;
  logic [8:0]  frac_row_in;
  logic signed [6:0] step_col;
  logic signed [6:0] step_row;

  modport source (
    output valid, operation, face_in, rotation_in, tile_col_in, tile_row_in,
           pix_col_in, pix_row_in, frac_col_in, frac_row_in, step_col, step_row,
    input  ready
  );
  modport sink (
    input  valid, operation, face_in, rotation_in, tile_col_in, tile_row_in,
           pix_col_in, pix_row_in, frac_col_in, frac_row_in, step_col, step_row,
    output ready
  );
endinterface

FILE: sv/cfc_res_if.sv
// ----------------------------------------------------------------------------
// cfc_res_if
// Result channel: the stepped cube coordinate.
// ----------------------------------------------------------------------------
interface cfc_res_if;
  logic        valid;
  logic        ready;
  logic [2:0]  face_out;
  logic [1:0]  rotation_out;
  logic [5:0]  tile_col_out;
  logic [5:0]  tile_row_out;
  logic [5:0]  pix_col_out;
  logic [5:0]  pix_row_out;
  logic [8:0]  frac_col_out;
  logic [8:0]  frac_row_out;

  modport source (
    output valid, face_out, rotation_out, tile_col_out, tile_row_out,
           pix_col_out, pix_row_out, frac_col_out, frac_row_out,
    input  ready
  );
  modport sink (
    input  valid, face_out, rotation_out, tile_col_out, tile_row_out,
           pix_col_out, pix_row_out, frac_col_out, frac_row_out,
    output ready
  );
endinterface

FILE: sv/cube_face_coordinate_step.sv
// ----------------------------------------------------------------------------
// cube_face_coordinate_step
// Steps a cube-surface coordinate by tiles or pixels, crossing face edges.
// ----------------------------------------------------------------------------
// Takes one request per cycle unless the result channel stalls, and returns
// one result per request, in order. The three register stages are pixel wrap,
// tile wrap with neighbour face lookup, and level rotation; each stage holds
// its item under backpressure and ready falls back stage by stage, so a full
// pipeline still takes a new request in the cycle its oldest result is taken.
// Face code 7 reads as none, oversized fractions are saturated and a step of
// -64 acts as -63. A corner crossing gives face none with unrotated coordinates.
module cube_face_coordinate_step (
  input  logic       clk_i,
  input  logic       rst_ni,
  cfc_req_if.sink    req_i,
  cfc_res_if.source  res_o
);

  cfc_pkg::req_t   req;
  cfc_pkg::mid_t   mid;
  cfc_pkg::edge_t  edg;
  cfc_pkg::res_t   res;
  logic            mid_valid, mid_ready;
  logic            edg_valid, edg_ready;

  always_comb begin
    req.operation = req_i.operation;
    req.face      = req_i.face_in;
    req.rot       = req_i.rotation_in;
    req.tc        = req_i.tile_col_in;
    req.tr        = req_i.tile_row_in;
    req.pc        = req_i.pix_col_in;
    req.pr        = req_i.pix_row_in;
    req.fc        = req_i.frac_col_in;
    req.fr        = req_i.frac_row_in;
    req.sc        = req_i.step_col;
    req.sr        = req_i.step_row;
  end

  cfc_wrap_stage u_wrap (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (req_i.valid),
    .ready_o (req_i.ready),
    .data_i  (req),
    .valid_o (mid_valid),
    .ready_i (mid_ready),
    .data_o  (mid)
  );

  cfc_edge_stage u_edge (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (mid_valid),
    .ready_o (mid_ready),
    .data_i  (mid),
    .valid_o (edg_valid),
    .ready_i (edg_ready),
    .data_o  (edg)
  );

  cfc_rotate_stage u_rotate (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (edg_valid),
    .ready_o (edg_ready),
    .data_i  (edg),
    .valid_o (res_o.valid),
    .ready_i (res_o.ready),
    .data_o  (res)
  );

  assign res_o.face_out     = res.face;
  assign res_o.rotation_out = res.rot;
  assign res_o.tile_col_out = res.tc;
  assign res_o.tile_row_out = res.tr;
  assign res_o.pix_col_out  = res.pc;
  assign res_o.pix_row_out  = res.pr;
  assign res_o.frac_col_out = res.fc;
  assign res_o.frac_row_out = res.fr;

endmodule

FILE: sv/cfc_wrap_stage.sv
// ----------------------------------------------------------------------------
// cfc_wrap_stage
// Input normalisation, step clamp and pixel wrap; in pixel mode turns pixel
// carries into a unit tile step, in tile mode passes the step on.
// ----------------------------------------------------------------------------
module cfc_wrap_stage (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  output logic            ready_o,
  input  cfc_pkg::req_t   data_i,
  output logic            valid_o,
  input  logic            ready_i,
  output cfc_pkg::mid_t   data_o
);

  logic                                  valid_q;
  cfc_pkg::mid_t                         data_d, data_q;
  logic signed [cfc_pkg::STEP_W-1:0]     sc, sr;
  logic [cfc_pkg::SUM_W-1:0]             px, py;
  logic signed [cfc_pkg::STEP_W-1:0]     cx, cy;

  always_comb begin
    sc = (data_i.sc < -cfc_pkg::STEP_LIM) ? -cfc_pkg::STEP_LIM : data_i.sc;
    sr = (data_i.sr < -cfc_pkg::STEP_LIM) ? -cfc_pkg::STEP_LIM : data_i.sr;

    // top bit: went below zero, next bit: went past the tile edge
    px = {2'b00, data_i.pc} + {sc[cfc_pkg::STEP_W-1], sc};
    py = {2'b00, data_i.pr} + {sr[cfc_pkg::STEP_W-1], sr};
    cx = px[cfc_pkg::SUM_W-1] ? cfc_pkg::STEP_NEG :
         px[cfc_pkg::SUM_W-2] ? cfc_pkg::STEP_POS : '0;
    cy = py[cfc_pkg::SUM_W-1] ? cfc_pkg::STEP_NEG :
         py[cfc_pkg::SUM_W-2] ? cfc_pkg::STEP_POS : '0;

    data_d.face = (data_i.face > cfc_pkg::FACE_NONE) ? cfc_pkg::FACE_NONE : data_i.face;
    data_d.rot  = data_i.rot;
    data_d.tc   = data_i.tc;
    data_d.tr   = data_i.tr;
    data_d.fc   = (data_i.fc > cfc_pkg::FRAC_ONE) ? cfc_pkg::FRAC_ONE : data_i.fc;
    data_d.fr   = (data_i.fr > cfc_pkg::FRAC_ONE) ? cfc_pkg::FRAC_ONE : data_i.fr;

    if (data_i.operation) begin
      data_d.pc       = px[cfc_pkg::PIX_W-1:0];
      data_d.pr       = py[cfc_pkg::PIX_W-1:0];
      data_d.sx       = cx;
      data_d.sy       = cy;
      data_d.keep_rot = (cx == '0) && (cy == '0);
    end else begin
      data_d.pc       = data_i.pc;
      data_d.pr       = data_i.pr;
      data_d.sx       = sc;
      data_d.sy       = sr;
      data_d.keep_rot = 1'b0;
    end
  end

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

endmodule

FILE: sv/cfc_edge_stage.sv
// ----------------------------------------------------------------------------
// cfc_edge_stage
// Tile step with wrap, edge-crossing detect and neighbour face lookup.
// ----------------------------------------------------------------------------
module cfc_edge_stage (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  output logic            ready_o,
  input  cfc_pkg::mid_t   data_i,
  output logic            valid_o,
  input  logic            ready_i,
  output cfc_pkg::edge_t  data_o
);

  logic                       valid_q;
  cfc_pkg::edge_t             data_d, data_q;
  logic [cfc_pkg::SUM_W-1:0]  tx, ty;
  logic                       real_face, hx, vy;
  cfc_pkg::orient_t           o_col, o_row;

  always_comb begin
    tx = {2'b00, data_i.tc} + {data_i.sx[cfc_pkg::STEP_W-1], data_i.sx};
    ty = {2'b00, data_i.tr} + {data_i.sy[cfc_pkg::STEP_W-1], data_i.sy};
    hx = tx[cfc_pkg::SUM_W-1] || tx[cfc_pkg::SUM_W-2];
    vy = ty[cfc_pkg::SUM_W-1] || ty[cfc_pkg::SUM_W-2];
    real_face = data_i.face < cfc_pkg::FACE_NONE;

    o_col = cfc_pkg::cfc_neighbor(data_i.face,
              tx[cfc_pkg::SUM_W-1] ? cfc_pkg::DIR_WEST : cfc_pkg::DIR_EAST);
    o_row = cfc_pkg::cfc_neighbor(data_i.face,
              ty[cfc_pkg::SUM_W-1] ? cfc_pkg::DIR_SOUTH : cfc_pkg::DIR_NORTH);

    // row edge wins when both are crossed; face none keeps its orientation
    data_d.face = data_i.face;
    data_d.rot  = data_i.rot;
    if (real_face && vy) begin
      data_d.face = o_row.face;
      data_d.rot  = o_row.rot;
    end else if (real_face && hx) begin
      data_d.face = o_col.face;
      data_d.rot  = o_col.rot;
    end

    data_d.tc       = tx[cfc_pkg::TILE_W-1:0];
    data_d.tr       = ty[cfc_pkg::TILE_W-1:0];
    data_d.pc       = data_i.pc;
    data_d.pr       = data_i.pr;
    data_d.fc       = data_i.fc;
    data_d.fr       = data_i.fr;
    data_d.hx       = hx;
    data_d.vy       = vy;
    data_d.keep_rot = data_i.keep_rot;
  end

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

endmodule

FILE: sv/cfc_rotate_stage.sv
// ----------------------------------------------------------------------------
// cfc_rotate_stage
// Final orientation and clockwise rotation of tile, pixel and
// fraction levels; output register of the block.
// ----------------------------------------------------------------------------
module cfc_rotate_stage (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  output logic            ready_o,
  input  cfc_pkg::edge_t  data_i,
  output logic            valid_o,
  input  logic            ready_i,
  output cfc_pkg::res_t   data_o
);

  logic           valid_q;
  cfc_pkg::res_t  data_d, data_q;
  logic [cfc_pkg::FRAC_W-1:0] fc_inv, fr_inv;

  always_comb begin
    fc_inv = cfc_pkg::FRAC_ONE - data_i.fc;
    fr_inv = cfc_pkg::FRAC_ONE - data_i.fr;

    data_d.face = data_i.face;
    data_d.rot  = data_i.rot;
    data_d.tc   = data_i.tc;
    data_d.tr   = data_i.tr;
    data_d.pc   = data_i.pc;
    data_d.pr   = data_i.pr;
    data_d.fc   = data_i.fc;
    data_d.fr   = data_i.fr;

    if (data_i.hx && data_i.vy) begin
      // corner: no defined neighbour
      data_d.face = cfc_pkg::FACE_NONE;
    end else if (!data_i.hx && !data_i.vy) begin
      if (!data_i.keep_rot) begin
        data_d.rot = cfc_pkg::ROT_0;
      end
    end else begin
      // size-1 minus x is the bitwise inverse for power-of-two grids
      case (data_i.rot)
        cfc_pkg::ROT_90: begin
          data_d.tc = data_i.tr;  data_d.tr = ~data_i.tc;
          data_d.pc = data_i.pr;  data_d.pr = ~data_i.pc;
          data_d.fc = data_i.fr;  data_d.fr = fc_inv;
        end
        cfc_pkg::ROT_180: begin
          data_d.tc = ~data_i.tc; data_d.tr = ~data_i.tr;
          data_d.pc = ~data_i.pc; data_d.pr = ~data_i.pr;
          data_d.fc = fc_inv;     data_d.fr = fr_inv;
        end
        cfc_pkg::ROT_270: begin
          data_d.tc = ~data_i.tr; data_d.tr = data_i.tc;
          data_d.pc = ~data_i.pr; data_d.pr = data_i.pc;
          data_d.fc = fr_inv;     data_d.fr = data_i.fc;
        end
        default: begin
        end
      endcase
    end
  end

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

endmodule
